[src/lspc_pkg.sv]
// Package for the LED status priority controller.
// Holds request opcodes, status, reason and LED codes, and the structs shared
// by the top level and the priority selector. No dependencies.
`default_nettype none

package lspc_pkg;

  typedef enum logic [3:0] {
    OP_TICK          = 4'd0,
    OP_SET_STATE     = 4'd1,
    OP_ACT_BEGIN     = 4'd2,
    OP_ACT_END       = 4'd3,
    OP_SET_FAULT     = 4'd4,
    OP_CLR_FAULT     = 4'd5,
    OP_SUCCESS       = 4'd6,
    OP_FAIL          = 4'd7,
    OP_OTA_BEGIN     = 4'd8,
    OP_OTA_END       = 4'd9,
    OP_FR_BEGIN      = 4'd10,
    OP_FR_END        = 4'd11,
    OP_POWEROFF_PEND = 4'd12,
    OP_RESTART_PEND  = 4'd13,
    OP_PREPARE_OFF   = 4'd14,
    OP_CANCEL_OFF    = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_IGNORED    = 3'd1,
    STS_BAD_SOURCE = 3'd2,
    STS_SATURATED  = 3'd3,
    STS_NO_BEGIN   = 3'd4,
    STS_BAD_STATE  = 3'd5,
    STS_UNKNOWN    = 3'd6,
    STS_TRACKING   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    RSN_POWER_OFF       = 4'd0,
    RSN_POWER_OFF_CNTDN = 4'd1,
    RSN_RESTART_PENDING = 4'd2,
    RSN_FATAL           = 4'd3,
    RSN_OTA             = 4'd4,
    RSN_FACTORY_RESET   = 4'd5,
    RSN_WIFI_FAULT      = 4'd6,
    RSN_SERVICE_FAULT   = 4'd7,
    RSN_EPD             = 4'd8,
    RSN_SHORT_ACTIVITY  = 4'd9,
    RSN_DATA_ACTIVITY   = 4'd10,
    RSN_SUCCESS         = 4'd11,
    RSN_OPERATION_FAIL  = 4'd12,
    RSN_BASE            = 4'd13
  } reason_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_SOLID = 2'd1,
    LED_BLINK = 2'd2
  } led_mode_t;

  typedef enum logic [1:0] {
    REG_SUCCESS_HOLD = 2'd0,
    REG_FAIL_HOLD    = 2'd1,
    REG_ACT_DELAY    = 2'd2
  } cfg_reg_t;

  localparam logic [3:0] RATE_NONE          = 4'd0;
  localparam logic [3:0] RATE_WIFI_CONNECT  = 4'd1;
  localparam logic [3:0] RATE_READY         = 4'd2;
  localparam logic [3:0] RATE_MID           = 4'd3;
  localparam logic [3:0] RATE_FAST          = 4'd4;
  localparam logic [3:0] RATE_WIFI_ERROR    = 4'd5;
  localparam logic [3:0] RATE_SERVICE_ERROR = 4'd6;
  localparam logic [3:0] RATE_EPD           = 4'd7;
  localparam logic [3:0] RATE_NETWORK       = 4'd8;

  // base and event state codes carried in the value field
  localparam logic [4:0] SC_OFF        = 5'd0;
  localparam logic [4:0] SC_BOOTING    = 5'd1;
  localparam logic [4:0] SC_WIFI_CONN  = 5'd2;
  localparam logic [4:0] SC_SRV_READY  = 5'd3;
  localparam logic [4:0] SC_EPD_REFR   = 5'd4;
  localparam logic [4:0] SC_EPD_DONE   = 5'd5;
  localparam logic [4:0] SC_SUCCESS    = 5'd6;
  localparam logic [4:0] SC_WIFI_FAIL  = 5'd7;
  localparam logic [4:0] SC_OP_FAIL    = 5'd8;
  localparam logic [4:0] SC_TRANSFER   = 5'd9;

  localparam logic [1:0] BASE_OFF      = 2'd0;
  localparam logic [1:0] BASE_BOOTING  = 2'd1;
  localparam logic [1:0] BASE_WIFI     = 2'd2;
  localparam logic [1:0] BASE_READY    = 2'd3;

  // mode flag bit positions
  localparam int FLAG_OTA      = 0;
  localparam int FLAG_FACTORY  = 1;
  localparam int FLAG_RESTART  = 2;
  localparam int FLAG_POWEROFF = 3;
  localparam int FLAG_SHUTDOWN = 4;

  localparam logic [4:0] FAULT_WIFI_MASK  = 5'b00011;
  localparam logic [4:0] FAULT_SRV_MASK   = 5'b01100;
  localparam logic [4:0] FAULT_LINK_MASK  = 5'b00111;
  localparam logic [4:0] FAULT_WIFI_AUTH  = 5'b00010;
  localparam int         FAULT_FATAL      = 4;

  localparam logic [2:0] SRC_EPD = 3'd3;

  localparam logic [15:0] RST_SUCCESS_HOLD = 16'd1000;
  localparam logic [15:0] RST_FAIL_HOLD    = 16'd1000;
  localparam logic [15:0] RST_ACT_DELAY    = 16'd50;

  typedef struct packed {
    logic [4:0] mode_flags;
    logic [4:0] fault_bits;
    logic [1:0] base_state;
    logic       epd_busy;
    logic       normal_busy;
    logic       delay_armed;
    logic       success_active;
    logic       fail_active;
  } led_view_t;

  typedef struct packed {
    led_mode_t  green_pattern;
    logic [3:0] green_rate;
    led_mode_t  red_pattern;
    logic [3:0] red_rate;
    reason_t    reason;
  } led_out_t;

endpackage

`default_nettype wire

[src/lspc_prio.sv]
// Fixed-priority LED effect selector for the LED status priority controller.
// Maps the updated controller state to LED modes, rates and a reason code.
// Depends on lspc_pkg.
`default_nettype none

module lspc_prio
  import lspc_pkg::*;
(
  input  led_view_t view,
  output led_out_t  led
);

  always_comb begin
    led.green_pattern = LED_OFF;
    led.green_rate    = RATE_NONE;
    led.red_pattern   = LED_OFF;
    led.red_rate      = RATE_NONE;
    led.reason        = RSN_BASE;
    if (view.mode_flags[FLAG_SHUTDOWN]) begin
      led.reason = RSN_POWER_OFF;
    end else if (view.mode_flags[FLAG_POWEROFF]) begin
      led.green_pattern = LED_SOLID;
      led.reason        = RSN_POWER_OFF_CNTDN;
    end else if (view.mode_flags[FLAG_RESTART] || view.fault_bits[FAULT_FATAL]) begin
      led.red_pattern = LED_SOLID;
      led.reason      = view.mode_flags[FLAG_RESTART] ? RSN_RESTART_PENDING : RSN_FATAL;
    end else if (view.mode_flags[FLAG_OTA]) begin
      led.green_pattern = LED_SOLID;
      led.red_pattern   = LED_BLINK;
      led.red_rate      = RATE_MID;
      led.reason        = RSN_OTA;
    end else if (view.mode_flags[FLAG_FACTORY]) begin
      led.green_pattern = LED_BLINK;
      led.green_rate    = RATE_FAST;
      led.red_pattern   = LED_SOLID;
      led.reason        = RSN_FACTORY_RESET;
    end else if ((view.fault_bits & FAULT_WIFI_MASK) != 5'd0) begin
      led.red_pattern = LED_BLINK;
      led.red_rate    = RATE_WIFI_ERROR;
      led.reason      = RSN_WIFI_FAULT;
    end else if ((view.fault_bits & FAULT_SRV_MASK) != 5'd0) begin
      led.red_pattern = LED_BLINK;
      led.red_rate    = RATE_SERVICE_ERROR;
      led.reason      = RSN_SERVICE_FAULT;
    end else begin
      case (view.base_state)
        BASE_BOOTING: begin
          led.green_pattern = LED_SOLID;
        end
        BASE_WIFI: begin
          led.green_pattern = LED_BLINK;
          led.green_rate    = RATE_WIFI_CONNECT;
        end
        BASE_READY: begin
          led.green_pattern = LED_BLINK;
          led.green_rate    = RATE_READY;
        end
        default: begin
          led.green_pattern = LED_OFF;
        end
      endcase
      if (view.epd_busy) begin
        led.red_pattern = LED_BLINK;
        led.red_rate    = RATE_EPD;
        led.reason      = RSN_EPD;
      end else if (view.normal_busy) begin
        if (view.delay_armed) begin
          led.red_pattern = LED_SOLID;
          led.reason      = RSN_SHORT_ACTIVITY;
        end else begin
          led.red_pattern = LED_BLINK;
          led.red_rate    = RATE_NETWORK;
          led.reason      = RSN_DATA_ACTIVITY;
        end
      end else if (view.success_active) begin
        led.green_pattern = LED_SOLID;
        led.green_rate    = RATE_NONE;
        led.reason        = RSN_SUCCESS;
      end else if (view.fail_active) begin
        led.red_pattern = LED_SOLID;
        led.reason      = RSN_OPERATION_FAIL;
      end else begin
        led.reason = RSN_BASE;
      end
    end
  end

endmodule

`default_nettype wire

[src/led_status_priority_controller.sv]
// LED status priority controller: one result per request, taken one request
// per clock. A request is registered on entry, applied to the status state by
// a single combinational pass and its LED result is registered on exit, so the
// throughput is one request per cycle whenever the result side takes results.
// Register writes take effect at once.
// Depends on lspc_pkg and lspc_prio.
`default_nettype none

module led_status_priority_controller
  import lspc_pkg::*;
#(
  parameter int NUM_SOURCES = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // op[3:0], source[6:4], value[11:7], zero[15:12]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // green_pattern[1:0], green_rate[5:2], red_pattern[7:6], red_rate[11:8],
  // reason_code[15:12], item_status[18:16], power_off_ack[19], zero[23:20]
  output logic [23:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int LANE_BITS = $clog2(NUM_SOURCES);
  localparam logic [LANE_BITS-1:0] EPD_LANE = LANE_BITS'(SRC_EPD);

  // config registers
  logic [15:0] success_hold_ticks;
  logic [15:0] fail_hold_ticks;
  logic [15:0] activity_delay_ticks;

  // input stage
  logic       in_valid;
  op_t        in_op;
  logic [2:0] in_src;
  logic [4:0] in_val;
  logic       advance;
  logic       fire;

  // status state
  logic [1:0]  base_state, base_state_next;
  logic [4:0]  fault_bits, fault_bits_next;
  logic [4:0]  mode_flags, mode_flags_next;
  logic        delay_armed, delay_armed_next;
  logic [15:0] delay_countdown, delay_countdown_next;
  logic        success_active, success_active_next;
  logic        fail_active, fail_active_next;
  logic [15:0] hold_countdown, hold_countdown_next;

  logic [COUNT_WIDTH-1:0] count      [NUM_SOURCES];
  logic [COUNT_WIDTH-1:0] count_next [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] lane_hit;
  logic [NUM_SOURCES-1:0] lane_max;
  logic [NUM_SOURCES-1:0] lane_zero;
  logic [NUM_SOURCES-1:0] lane_normal_nz;
  logic [NUM_SOURCES-1:0] lane_normal_nz_next;

  // activity decisions
  logic    src_bad;
  logic    src_epd;
  logic    act_inc;
  logic    act_dec;
  logic    act_clr;
  status_t status;
  logic    normal_busy;
  logic    normal_busy_next;
  logic    shut;

  // result stage
  led_view_t view;
  led_out_t  led;
  led_out_t  res_led;
  status_t   res_status;
  logic      res_ack;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign fire      = in_valid && advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= op_t'(s_tdata[3:0]);
      in_src <= s_tdata[6:4];
      in_val <= s_tdata[11:7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      success_hold_ticks   <= RST_SUCCESS_HOLD;
      fail_hold_ticks      <= RST_FAIL_HOLD;
      activity_delay_ticks <= RST_ACT_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SUCCESS_HOLD: success_hold_ticks   <= cfg_data;
        REG_FAIL_HOLD:    fail_hold_ticks      <= cfg_data;
        REG_ACT_DELAY:    activity_delay_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // per-source activity counters
  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_lane
    assign lane_hit[i]  = (in_src == 3'(i));
    assign lane_max[i]  = (count[i] == CNT_MAX);
    assign lane_zero[i] = (count[i] == '0);

    always_comb begin
      count_next[i] = count[i];
      if (act_clr) begin
        count_next[i] = '0;
      end else if (act_inc && lane_hit[i]) begin
        count_next[i] = count[i] + 1'b1;
      end else if (act_dec && lane_hit[i]) begin
        count_next[i] = count[i] - 1'b1;
      end
    end

    if (i == int'(SRC_EPD)) begin : g_epd
      assign lane_normal_nz[i]      = 1'b0;
      assign lane_normal_nz_next[i] = 1'b0;
    end else begin : g_normal
      assign lane_normal_nz[i]      = !lane_zero[i];
      assign lane_normal_nz_next[i] = (count_next[i] != '0);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        count[i] <= '0;
      end else if (fire) begin
        count[i] <= count_next[i];
      end
    end
  end

  assign src_bad          = ({1'b0, in_src} >= 4'(NUM_SOURCES));
  assign src_epd          = (in_src == SRC_EPD);
  assign normal_busy      = |lane_normal_nz;
  assign normal_busy_next = |lane_normal_nz_next;
  assign shut             = mode_flags[FLAG_SHUTDOWN];

  always_comb begin
    act_inc = 1'b0;
    act_dec = 1'b0;
    act_clr = 1'b0;
    status  = STS_OK;
    case (in_op)
      OP_TICK: begin
        status = STS_OK;
      end
      OP_PREPARE_OFF: begin
        act_clr = 1'b1;
      end
      OP_CANCEL_OFF: begin
        status = STS_OK;
      end
      OP_SET_STATE: begin
        if (shut) begin
          status = STS_IGNORED;
        end else if (in_val > SC_TRANSFER) begin
          status = STS_BAD_STATE;
        end else if (in_val == SC_EPD_REFR || in_val == SC_EPD_DONE
                     || in_val == SC_TRANSFER) begin
          status = STS_TRACKING;
        end
      end
      OP_ACT_BEGIN: begin
        if (shut) begin
          status = STS_IGNORED;
        end else if (src_bad) begin
          status = STS_BAD_SOURCE;
        end else if (|(lane_hit & lane_max)) begin
          status = STS_SATURATED;
        end else begin
          act_inc = 1'b1;
        end
      end
      OP_ACT_END: begin
        if (shut) begin
          status = STS_IGNORED;
        end else if (src_bad) begin
          status = STS_BAD_SOURCE;
        end else if (|(lane_hit & lane_zero)) begin
          status = STS_NO_BEGIN;
        end else begin
          act_dec = 1'b1;
        end
      end
      default: begin
        status = shut ? STS_IGNORED : STS_OK;
      end
    endcase
  end

  always_comb begin
    base_state_next      = base_state;
    fault_bits_next      = fault_bits;
    mode_flags_next      = mode_flags;
    delay_armed_next     = delay_armed;
    delay_countdown_next = delay_countdown;
    success_active_next  = success_active;
    fail_active_next     = fail_active;
    hold_countdown_next  = hold_countdown;
    case (in_op)
      OP_TICK: begin
        if (delay_countdown != 16'd0) begin
          delay_countdown_next = delay_countdown - 16'd1;
        end
        if (hold_countdown != 16'd0) begin
          hold_countdown_next = hold_countdown - 16'd1;
        end
      end
      OP_PREPARE_OFF: begin
        mode_flags_next[FLAG_SHUTDOWN] = 1'b1;
        mode_flags_next[FLAG_POWEROFF] = 1'b0;
        delay_armed_next               = 1'b0;
        success_active_next            = 1'b0;
        fail_active_next               = 1'b0;
      end
      OP_CANCEL_OFF: begin
        mode_flags_next[FLAG_SHUTDOWN] = 1'b0;
        mode_flags_next[FLAG_POWEROFF] = 1'b0;
      end
      OP_SET_STATE: begin
        if (!shut) begin
          case (in_val)
            SC_OFF, SC_BOOTING: begin
              base_state_next = in_val[1:0];
            end
            SC_WIFI_CONN, SC_SRV_READY: begin
              base_state_next = in_val[1:0];
              fault_bits_next = fault_bits & ~FAULT_LINK_MASK;
            end
            SC_SUCCESS: begin
              success_active_next = 1'b1;
              fail_active_next    = 1'b0;
              hold_countdown_next = success_hold_ticks;
            end
            SC_WIFI_FAIL: begin
              fault_bits_next = fault_bits | FAULT_WIFI_AUTH;
            end
            SC_OP_FAIL: begin
              success_active_next = 1'b0;
              fail_active_next    = 1'b1;
              hold_countdown_next = fail_hold_ticks;
            end
            default: begin
            end
          endcase
        end
      end
      OP_ACT_BEGIN: begin
        if (act_inc && !src_epd && !normal_busy) begin
          delay_armed_next     = 1'b1;
          delay_countdown_next = activity_delay_ticks;
        end
      end
      OP_ACT_END: begin
        if (act_dec && !src_epd && !normal_busy_next) begin
          delay_armed_next = 1'b0;
        end
      end
      OP_SET_FAULT: begin
        if (!shut) begin
          fault_bits_next = fault_bits | in_val;
        end
      end
      OP_CLR_FAULT: begin
        if (!shut) begin
          fault_bits_next = fault_bits & ~in_val;
        end
      end
      OP_SUCCESS: begin
        if (!shut) begin
          success_active_next = 1'b1;
          fail_active_next    = 1'b0;
          hold_countdown_next = success_hold_ticks;
        end
      end
      OP_FAIL: begin
        if (!shut) begin
          success_active_next = 1'b0;
          fail_active_next    = 1'b1;
          hold_countdown_next = fail_hold_ticks;
        end
      end
      OP_OTA_BEGIN: begin
        if (!shut) begin
          mode_flags_next[FLAG_OTA] = 1'b1;
        end
      end
      OP_OTA_END: begin
        if (!shut) begin
          mode_flags_next[FLAG_OTA] = 1'b0;
          if (in_val[0]) begin
            mode_flags_next[FLAG_RESTART] = 1'b1;
          end
        end
      end
      OP_FR_BEGIN: begin
        if (!shut) begin
          mode_flags_next[FLAG_FACTORY] = 1'b1;
        end
      end
      OP_FR_END: begin
        if (!shut) begin
          mode_flags_next[FLAG_FACTORY] = 1'b0;
        end
      end
      OP_POWEROFF_PEND: begin
        if (!shut) begin
          mode_flags_next[FLAG_POWEROFF] = in_val[0];
        end
      end
      OP_RESTART_PEND: begin
        if (!shut) begin
          mode_flags_next[FLAG_RESTART] = in_val[0];
        end
      end
      default: begin
      end
    endcase

    // expire timers after every request
    if (delay_armed_next && delay_countdown_next == 16'd0) begin
      delay_armed_next = 1'b0;
    end
    if ((success_active_next || fail_active_next) && hold_countdown_next == 16'd0) begin
      success_active_next = 1'b0;
      fail_active_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_state      <= BASE_BOOTING;
      fault_bits      <= '0;
      mode_flags      <= '0;
      delay_armed     <= 1'b0;
      delay_countdown <= '0;
      success_active  <= 1'b0;
      fail_active     <= 1'b0;
      hold_countdown  <= '0;
    end else if (fire) begin
      base_state      <= base_state_next;
      fault_bits      <= fault_bits_next;
      mode_flags      <= mode_flags_next;
      delay_armed     <= delay_armed_next;
      delay_countdown <= delay_countdown_next;
      success_active  <= success_active_next;
      fail_active     <= fail_active_next;
      hold_countdown  <= hold_countdown_next;
    end
  end

  always_comb begin
    view.mode_flags     = mode_flags_next;
    view.fault_bits     = fault_bits_next;
    view.base_state     = base_state_next;
    view.epd_busy       = (count_next[EPD_LANE] != '0);
    view.normal_busy    = normal_busy_next;
    view.delay_armed    = delay_armed_next;
    view.success_active = success_active_next;
    view.fail_active    = fail_active_next;
  end

  lspc_prio u_prio (
    .view (view),
    .led  (led)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_led    <= led;
      res_status <= status;
      res_ack    <= (in_op == OP_PREPARE_OFF) || (in_op == OP_CANCEL_OFF);
    end
  end

  assign m_tdata = {4'd0, res_ack, res_status, res_led.reason, res_led.red_rate,
                    res_led.red_pattern, res_led.green_rate, res_led.green_pattern};

  a_shutdown_ignores : assert property (@(posedge clk) disable iff (rst)
    fire && shut && in_op != OP_TICK && in_op != OP_PREPARE_OFF && in_op != OP_CANCEL_OFF
    |=> m_tvalid && res_status == STS_IGNORED)
    else $error("request in shutdown not reported as ignored");

  a_prepare_clears : assert property (@(posedge clk) disable iff (rst)
    fire && in_op == OP_PREPARE_OFF
    |=> !normal_busy && lane_zero[EPD_LANE] && mode_flags[FLAG_SHUTDOWN] && res_ack)
    else $error("prepare left activity or missed shutdown");

  a_hold_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(success_active && fail_active))
    else $error("success and fail holds both active");

  a_delay_needs_activity : assert property (@(posedge clk) disable iff (rst)
    delay_armed |-> normal_busy)
    else $error("activity delay armed with no normal activity");

  a_ack_ok : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_ack |-> res_status == STS_OK)
    else $error("power-off acknowledge with non-ok status");

endmodule

`default_nettype wire
